>>> rtl/dvrt_pkg.sv
// shared types and constants for the distance-vector route table
// no dependencies
`default_nettype none
package dvrt_pkg;
   localparam int SERVERS    = 16;
   localparam int IDX_W      = 4;
   localparam int COST_W     = 15;
   localparam int ADDR_W     = 2 * IDX_W;
   localparam logic [COST_W-1:0] INF_COST = 15'h7fff;

   localparam logic [1:0] KIND_SET_LINK = 2'd0;
   localparam logic [1:0] KIND_VECTOR   = 2'd1;
   localparam logic [1:0] KIND_READ_ROW = 2'd2;
   localparam logic [1:0] KIND_UNUSED   = 2'd3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [IDX_W-1:0]  server;
      logic [IDX_W-1:0]  entry_dest;
      logic [COST_W-1:0] cost;
      logic              present;
      logic              link_up;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  dest;
      logic [COST_W-1:0] route_cost;
      logic [IDX_W-1:0]  next_hop;
      logic              hop_valid;
      logic              row_end;
   } rsp_type;
endpackage
`default_nettype wire

>>> rtl/distance_vector_route_table.sv
// distance-vector route table top level: cost table memory and update sequencer
// depends on dvrt_pkg
//
// Items are taken one at a time. A set_link, a last vector entry or an own_index
// write starts a recompute of the own row, one destination after another (one
// table read per neighbour through the single read port of the cost memory, plus
// setup and write-back); req_ready stays low meanwhile. An own_index write that
// arrives while the block is busy is held and applied once it is idle. A plain
// vector entry is written without a recompute. A read_row emits 16 beats, each
// held until rsp_ready. Table entries never written read as infinity (zero
// for entry 0) through per-entry valid bits, so no clearing pass is needed
// after reset.
`default_nettype none
module distance_vector_route_table (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dvrt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dvrt_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [dvrt_pkg::IDX_W-1:0] csr_wr_data
);
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIAG   = 3'd1;
   localparam logic [2:0] ST_DSTART = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_WRITE  = 3'd4;
   localparam logic [2:0] ST_ISSUE  = 3'd5;
   localparam logic [2:0] ST_LOAD   = 3'd6;
   localparam logic [2:0] ST_SEND   = 3'd7;

   localparam int N  = dvrt_pkg::SERVERS;
   localparam int IW = dvrt_pkg::IDX_W;
   localparam int CW = dvrt_pkg::COST_W;
   localparam int AW = dvrt_pkg::ADDR_W;
   localparam logic [IW:0] K_LAST = IW'(N - 1) + 1'b1;
   localparam logic [IW-1:0] D_LAST = IW'(N - 1);

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] own_ff, own_in;
   logic          csr_pend_ff, csr_pend_in;
   logic [IW-1:0] csr_data_ff, csr_data_in;
   logic [IW-1:0] d_ff, d_in;
   logic [IW:0]   k_ff, k_in;
   logic [CW-1:0] best_ff, best_in;
   logic [IW-1:0] hop_ff, hop_in;
   logic [CW-1:0] lcost_ff [N], lcost_in [N];
   logic [N-1:0]  lpres_ff, lpres_in, lup_ff, lup_in;
   logic [IW-1:0] nhop_ff [N], nhop_in [N];
   logic [N-1:0]  hvalid_ff, hvalid_in;
   logic [N*N-1:0] evalid_ff, evalid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   dvrt_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // cost table memory, one read and one write port
   logic [CW-1:0] mem [N*N];
   logic [CW-1:0] mem_rdata_ff;
   logic          rd_valid_ff, rd_zero_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [CW-1:0] mem_wdata, rd_cost;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
      rd_valid_ff  <= evalid_ff[mem_raddr];
      rd_zero_ff   <= (mem_raddr == '0);
   end

   assign rd_cost = rd_valid_ff ? mem_rdata_ff : (rd_zero_ff ? '0 : dvrt_pkg::INF_COST);

   logic [IW-1:0] cmp_n, lk;
   logic          lk_ok;
   logic [CW:0]   sum;
   logic          accept;

   assign cmp_n = k_ff[IW-1:0] - 1'b1;
   assign lk    = (state_ff == ST_SCAN) ? cmp_n : d_ff;
   assign lk_ok = lpres_ff[lk] & lup_ff[lk];
   assign sum   = {1'b0, rd_cost} + {1'b0, lcost_ff[lk]};
   assign mem_raddr = (state_ff == ST_SCAN) ? {k_ff[IW-1:0], d_ff} : {own_ff, d_ff};
   assign req_ready = (state_ff == ST_IDLE) & ~csr_pend_ff & ~csr_wr_en;
   assign accept    = req_valid & req_ready;

   always_comb begin
      state_in     = state_ff;
      own_in       = own_ff;
      csr_pend_in  = csr_pend_ff;
      csr_data_in  = csr_data_ff;
      d_in         = d_ff;
      k_in         = k_ff;
      best_in      = best_ff;
      hop_in       = hop_ff;
      lcost_in     = lcost_ff;
      lpres_in     = lpres_ff;
      lup_in       = lup_ff;
      nhop_in      = nhop_ff;
      hvalid_in    = hvalid_ff;
      evalid_in    = evalid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = {own_ff, d_ff};
      mem_wdata    = best_ff;
      // hold a write that lands while busy
      if (csr_wr_en) begin
         csr_pend_in = 1'b1;
         csr_data_in = csr_wr_data;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_wr_en) begin
               own_in      = csr_wr_data;
               csr_pend_in = 1'b0;
               state_in    = ST_DIAG;
            end else if (csr_pend_ff) begin
               own_in      = csr_data_ff;
               csr_pend_in = 1'b0;
               state_in    = ST_DIAG;
            end else if (accept) begin
               unique case (req_data.kind)
                  dvrt_pkg::KIND_SET_LINK: begin
                     if (req_data.server != own_ff) begin
                        lcost_in[req_data.server] = req_data.cost;
                        lpres_in[req_data.server] = req_data.present;
                        lup_in[req_data.server]   = req_data.link_up;
                        state_in = ST_DIAG;
                     end
                  end
                  dvrt_pkg::KIND_VECTOR: begin
                     if (req_data.server != own_ff && lpres_ff[req_data.server]) begin
                        mem_we    = 1'b1;
                        mem_waddr = {req_data.server, req_data.entry_dest};
                        mem_wdata = req_data.cost;
                        evalid_in[{req_data.server, req_data.entry_dest}] = 1'b1;
                        if (req_data.last) begin
                           lup_in[req_data.server] = 1'b1;
                           state_in = ST_DIAG;
                        end
                     end
                  end
                  dvrt_pkg::KIND_READ_ROW: begin
                     d_in     = '0;
                     state_in = ST_ISSUE;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIAG: begin
            mem_we    = 1'b1;
            mem_waddr = {own_ff, own_ff};
            mem_wdata = '0;
            evalid_in[{own_ff, own_ff}] = 1'b1;
            nhop_in[own_ff]   = own_ff;
            hvalid_in[own_ff] = 1'b1;
            d_in     = '0;
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            if (d_ff == own_ff) begin
               if (d_ff == D_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  d_in = d_ff + 1'b1;
               end
            end else begin
               best_in  = lk_ok ? lcost_ff[lk] : dvrt_pkg::INF_COST;
               hop_in   = lk_ok ? d_ff : '0;
               k_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // reads issue at k, the compare for neighbour k-1 sees the data
            if (k_ff != '0 && lk_ok && sum < {1'b0, best_ff}) begin
               best_in = sum[CW-1:0];
               hop_in  = cmp_n;
            end
            if (k_ff == K_LAST) begin
               state_in = ST_WRITE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            mem_we = 1'b1;
            evalid_in[{own_ff, d_ff}] = 1'b1;
            nhop_in[d_ff]   = (best_ff == dvrt_pkg::INF_COST) ? '0 : hop_ff;
            hvalid_in[d_ff] = (best_ff != dvrt_pkg::INF_COST);
            if (d_ff == D_LAST) begin
               state_in = ST_IDLE;
            end else begin
               d_in     = d_ff + 1'b1;
               state_in = ST_DSTART;
            end
         end
         ST_ISSUE: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rsp_data_in.dest       = d_ff;
            rsp_data_in.route_cost = rd_cost;
            rsp_data_in.next_hop   = nhop_ff[d_ff];
            rsp_data_in.hop_valid  = hvalid_ff[d_ff];
            rsp_data_in.row_end    = (d_ff == D_LAST);
            rsp_valid_in = 1'b1;
            state_in     = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (d_ff == D_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  d_in     = d_ff + 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         own_ff       <= '0;
         csr_pend_ff  <= 1'b0;
         d_ff         <= '0;
         k_ff         <= '0;
         lpres_ff     <= '0;
         lup_ff       <= '0;
         hvalid_ff    <= N'(1);
         evalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            lcost_ff[i] <= dvrt_pkg::INF_COST;
            nhop_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         own_ff       <= own_in;
         csr_pend_ff  <= csr_pend_in;
         d_ff         <= d_in;
         k_ff         <= k_in;
         lpres_ff     <= lpres_in;
         lup_ff       <= lup_in;
         hvalid_ff    <= hvalid_in;
         evalid_ff    <= evalid_in;
         rsp_valid_ff <= rsp_valid_in;
         lcost_ff     <= lcost_in;
         nhop_ff      <= nhop_in;
      end
      csr_data_ff <= csr_data_in;
      best_ff     <= best_in;
      hop_ff      <= hop_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
`default_nettype wire

>>> verif/distance_vector_route_table_tb.sv
// testbench for the distance-vector route table: directed and random items
// against an in-bench route predictor; depends on dvrt_pkg and the top level
`timescale 1ns / 1ps
module distance_vector_route_table_tb;
   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 400;
   localparam int REQ_W = $bits(dvrt_pkg::req_type);
   localparam int SERVERS = dvrt_pkg::SERVERS;
   localparam int IDX_W = dvrt_pkg::IDX_W;
   localparam int COST_W = dvrt_pkg::COST_W;
   localparam logic [COST_W:0] INF_WIDE = {1'b0, dvrt_pkg::INF_COST};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   dvrt_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   dvrt_pkg::rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [IDX_W-1:0] csr_wr_data = '0;

   distance_vector_route_table i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   // predicted state
   logic [COST_W-1:0] peer_cost [SERVERS][SERVERS];
   logic [IDX_W-1:0] best_hop [SERVERS];
   logic hop_ok [SERVERS];
   logic [COST_W-1:0] link_cost [SERVERS];
   logic link_present [SERVERS];
   logic link_alive [SERVERS];
   logic [IDX_W-1:0] own_idx;

   dvrt_pkg::rsp_type route_q[$];
   int errors = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit recv_hold = 1'b0;
   bit timed_out = 1'b0;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic void clear_routes();
      for (int i = 0; i < SERVERS; i++) begin
         for (int j = 0; j < SERVERS; j++) peer_cost[i][j] = dvrt_pkg::INF_COST;
         link_cost[i] = dvrt_pkg::INF_COST;
         best_hop[i] = '0;
         hop_ok[i] = 1'b0;
         link_present[i] = 1'b0;
         link_alive[i] = 1'b0;
      end
      own_idx = '0;
      peer_cost[0][0] = '0;
      hop_ok[0] = 1'b1;
   endfunction

   function automatic void relax_own_row();
      int me;
      logic [COST_W:0] best, sum;
      logic [IDX_W-1:0] hop;
      me = int'(own_idx);
      peer_cost[me][me] = '0;
      best_hop[me] = own_idx;
      hop_ok[me] = 1'b1;
      for (int d = 0; d < SERVERS; d++) begin
         if (d == me) continue;
         best = INF_WIDE;
         hop = '0;
         if (link_present[d] && link_alive[d]) begin
            best = {1'b0, link_cost[d]};
            hop = d[IDX_W-1:0];
         end
         for (int n = 0; n < SERVERS; n++) begin
            if (!(link_present[n] && link_alive[n])) continue;
            sum = {1'b0, peer_cost[n][d]} + {1'b0, link_cost[n]};
            if (sum < best) begin
               best = sum;
               hop = n[IDX_W-1:0];
            end
         end
         peer_cost[me][d] = best[COST_W-1:0];
         best_hop[d] = (best >= INF_WIDE) ? '0 : hop;
         hop_ok[d] = (best < INF_WIDE);
      end
   endfunction

   function automatic void predict_item(input dvrt_pkg::req_type r);
      dvrt_pkg::rsp_type e;
      case (r.kind)
         dvrt_pkg::KIND_SET_LINK: begin
            if (r.server != own_idx) begin
               link_cost[r.server] = r.cost;
               link_present[r.server] = r.present;
               link_alive[r.server] = r.link_up;
               relax_own_row();
            end
         end
         dvrt_pkg::KIND_VECTOR: begin
            if (r.server != own_idx && link_present[r.server]) begin
               peer_cost[r.server][r.entry_dest] = r.cost;
               if (r.last) begin
                  link_alive[r.server] = 1'b1;
                  relax_own_row();
               end
            end
         end
         dvrt_pkg::KIND_READ_ROW: begin
            for (int i = 0; i < SERVERS; i++) begin
               e.dest = i[IDX_W-1:0];
               e.route_cost = peer_cost[own_idx][i];
               e.next_hop = best_hop[i];
               e.hop_valid = hop_ok[i];
               e.row_end = (i == SERVERS - 1);
               route_q = {route_q, e};
            end
         end
         default: ;
      endcase
   endfunction

   // result checker and watchdog
   always @(posedge clock) begin
      dvrt_pkg::rsp_type e;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("FAILED: results differ");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (route_q.size() == 0) report("unexpected beat dest", int'(rsp_data.dest), -1);
            else begin
               e = route_q.pop_front();
               if (rsp_data.dest !== e.dest)
                  report("dest", int'(rsp_data.dest), int'(e.dest));
               if (rsp_data.route_cost !== e.route_cost)
                  report("route_cost", int'(rsp_data.route_cost), int'(e.route_cost));
               if (rsp_data.next_hop !== e.next_hop)
                  report("next_hop", int'(rsp_data.next_hop), int'(e.next_hop));
               if (rsp_data.hop_valid !== e.hop_valid)
                  report("hop_valid", int'(rsp_data.hop_valid), int'(e.hop_valid));
               if (rsp_data.row_end !== e.row_end)
                  report("row_end", int'(rsp_data.row_end), int'(e.row_end));
            end
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (reset || recv_hold) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // valid stays high between beats sent back to back; drain drops it
   task automatic send_item(input dvrt_pkg::req_type r);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(r);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (route_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_own_index(input logic [IDX_W-1:0] v);
      drain();
      csr_wr_data <= v;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      own_idx = v;
      relax_own_row();
   endtask

   function automatic dvrt_pkg::req_type make_req(input logic [1:0] k, input int s, input int d,
                                                  input int c, input int p, input int u,
                                                  input int l);
      dvrt_pkg::req_type r;
      r.kind = k;
      r.server = s[IDX_W-1:0];
      r.entry_dest = d[IDX_W-1:0];
      r.cost = c[COST_W-1:0];
      r.present = (p != 0);
      r.link_up = (u != 0);
      r.last = (l != 0);
      return r;
   endfunction

   function automatic dvrt_pkg::req_type random_req();
      dvrt_pkg::req_type r;
      int pick;
      r = dvrt_pkg::req_type'(REQ_W'($urandom));
      pick = $urandom_range(99);
      if (pick < 25) r.kind = dvrt_pkg::KIND_SET_LINK;
      else if (pick < 75) r.kind = dvrt_pkg::KIND_VECTOR;
      else if (pick < 96) r.kind = dvrt_pkg::KIND_READ_ROW;
      else r.kind = dvrt_pkg::KIND_UNUSED;
      // mostly real neighbours, small costs so sums win
      if ($urandom_range(3) != 0) r.server = IDX_W'($urandom_range(5));
      if (r.kind == dvrt_pkg::KIND_SET_LINK) r.present = ($urandom_range(4) != 0);
      if (r.kind == dvrt_pkg::KIND_VECTOR) r.last = ($urandom_range(3) == 0);
      pick = $urandom_range(9);
      if (pick < 6) r.cost = COST_W'($urandom_range(200));
      else if (pick == 6) r.cost = dvrt_pkg::INF_COST;
      else if (pick == 7) r.cost = dvrt_pkg::INF_COST - COST_W'($urandom_range(3));
      return r;
   endfunction

   task automatic test_directed();
      send_item(make_req(dvrt_pkg::KIND_READ_ROW, 0, 0, 0, 0, 0, 0));
      send_item(make_req(dvrt_pkg::KIND_SET_LINK, 0, 0, 5, 1, 1, 0));   // own server, ignored
      send_item(make_req(dvrt_pkg::KIND_SET_LINK, 15, 15, 32766, 1, 1, 1));
      send_item(make_req(dvrt_pkg::KIND_SET_LINK, 1, 0, 0, 1, 1, 0));
      send_item(make_req(dvrt_pkg::KIND_SET_LINK, 2, 0, 3, 1, 0, 0));   // present, down
      send_item(make_req(dvrt_pkg::KIND_VECTOR, 3, 4, 1, 1, 1, 1));     // non-neighbour
      send_item(make_req(dvrt_pkg::KIND_VECTOR, 2, 7, 2, 0, 0, 0));
      send_item(make_req(dvrt_pkg::KIND_VECTOR, 2, 15, 32767, 1, 1, 1)); // brings link 2 up
      send_item(make_req(dvrt_pkg::KIND_VECTOR, 1, 9, 32767, 0, 0, 1));  // sum stays inf
      send_item(make_req(dvrt_pkg::KIND_VECTOR, 15, 8, 1, 0, 0, 1));     // 32766 + 1 stays inf
      send_item(make_req(dvrt_pkg::KIND_UNUSED, 5, 5, 9, 1, 1, 1));
      send_item(make_req(dvrt_pkg::KIND_READ_ROW, 15, 15, 32767, 1, 1, 1));
      send_item(make_req(dvrt_pkg::KIND_SET_LINK, 1, 0, 32767, 1, 1, 0)); // unreachable direct
      send_item(make_req(dvrt_pkg::KIND_SET_LINK, 2, 0, 4, 0, 1, 0));
      send_item(make_req(dvrt_pkg::KIND_READ_ROW, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_own_index();
      write_own_index(4'd15);
      send_item(make_req(dvrt_pkg::KIND_SET_LINK, 15, 0, 1, 1, 1, 0));  // now own, ignored
      send_item(make_req(dvrt_pkg::KIND_SET_LINK, 0, 0, 2, 1, 1, 0));
      send_item(make_req(dvrt_pkg::KIND_READ_ROW, 0, 0, 0, 0, 0, 0));
      write_own_index(4'd7);
      send_item(make_req(dvrt_pkg::KIND_READ_ROW, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic run_random(input int count, input int s_pct, input int r_pct);
      send_idle_pct = s_pct;
      recv_stall_pct = r_pct;
      for (int i = 0; i < count; i++) send_item(random_req());
   endtask

   task automatic test_backpressure();
      fork
         begin
            recv_hold = 1'b1;
            repeat (300) @(negedge clock);
            recv_hold = 1'b0;
         end
         for (int i = 0; i < 4; i++)
            send_item(make_req(dvrt_pkg::KIND_READ_ROW, 0, 0, 0, 0, 0, 0));
      join
      drain();
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      clear_routes();
      @(negedge clock);
      test_directed();
      test_own_index();
      run_random(80, 0, 0);
      test_backpressure();
      write_own_index(4'd0);
      run_random(80, 70, 0);
      write_own_index(4'd3);
      run_random(80, 0, 70);
      write_own_index(4'd9);
      run_random(80, 22, 22);
      drain();
      if (errors == 0 && route_q.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end
endmodule
